[rtl/biquad_lowpass_derivative_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the biquad low-pass derivative core
// Concurrent check wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_LOWPASS_DERIVATIVE_CORE_MACROS_SVH
`define BIQUAD_LOWPASS_DERIVATIVE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication check
`define BQD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqd same-cycle check failed");

// Next-cycle implication check
`define BQD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqd next-cycle check failed");

`else

`define BQD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BQD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/bqd_pkg.sv]
// ----------------------------------------------------------------------------
// Biquad low-pass derivative package
// Shared widths, register map, sequencer states and defaults.
// ----------------------------------------------------------------------------
package bqd_pkg;

   // Field widths
   localparam int SAMPLE_W = 32;
   localparam int STEP_W   = 20;
   localparam int COEF_W   = 32;
   localparam int ADDR_W   = 5;
   localparam int PDATA_W  = 32;

   // Default parameter values
   localparam int DATA_WIDTH_DEF     = 32;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // Datapath widths: multiplier operands, accumulator, divider
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 67;
   localparam int NUM_W   = 53;
   localparam int DIV_BITS = 33;
   localparam int CNT_W   = 6;

   localparam logic signed [MUL_W-1:0] US_PER_SECOND = 33'sd1000000;

   // Register map (word index)
   typedef enum logic [2:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_index_type;

   // Sequencer states
   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_MAC   = 12'b0000_0000_0010,
      ST_DRAIN = 12'b0000_0000_0100,
      ST_ROUND = 12'b0000_0000_1000,
      ST_DIFF  = 12'b0000_0001_0000,
      ST_RMUL  = 12'b0000_0010_0000,
      ST_ABS   = 12'b0000_0100_0000,
      ST_ADD   = 12'b0000_1000_0000,
      ST_CHECK = 12'b0001_0000_0000,
      ST_DIV   = 12'b0010_0000_0000,
      ST_SAT   = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_PRESET = 1'b1;

endpackage

[rtl/bqd_channels.sv]
// ----------------------------------------------------------------------------
// Biquad low-pass derivative channels
// Valid/ready interfaces for the request and response streams.
// ----------------------------------------------------------------------------
interface bqd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [bqd_pkg::SAMPLE_W-1:0]  sample_value;
   logic        [bqd_pkg::STEP_W-1:0]    step_us;

   modport source (output valid, kind, sample_value, step_us, input ready);
   modport sink   (input valid, kind, sample_value, step_us, output ready);
endinterface

interface bqd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bqd_pkg::SAMPLE_W-1:0]  filtered_value;
   logic signed [bqd_pkg::SAMPLE_W-1:0]  rate_value;
   logic                                 rate_valid;

   modport source (output valid, filtered_value, rate_value, rate_valid, input ready);
   modport sink   (input valid, filtered_value, rate_value, rate_valid, output ready);
endinterface

[rtl/biquad_lowpass_derivative_core.sv]
// ----------------------------------------------------------------------------
// Biquad low-pass derivative core
// Direct form I biquad with derivative output, built around one shared
// 33x33 multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   req_if    in         valid/ready        kind, sample_value, step_us
//   rsp_if    out        valid/ready        filtered_value, rate_value, rate_valid
//   apb       in         psel/penable/pwrite coef_b0 .. coef_a2 at 0x00 .. 0x10
//
// A sample with a computed rate passes from acceptance to the output
// register through 5 multiplies plus drain and round, 6 steps around the
// divide, the divider, which sets most of the delay, and the hand-off; a
// rate out of range skips the divider. A forced-zero rate skips the rate
// steps, the first sample after reset goes straight to the hand-off, and a
// preset finishes at its acceptance edge. Request ready is high only while
// the sequencer is idle, so a sample is taken only after the last one is
// handed off; a finished result waits in the output register and stalls
// the sequencer only when a second result is ready before the first is taken.
// Reset is synchronous, active high, and needs no clearing pass.
//
`include "biquad_lowpass_derivative_core_macros.svh"

module biquad_lowpass_derivative_core #(
   parameter int DATA_WIDTH     = bqd_pkg::DATA_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bqd_req_if.sink                       req_if,
   bqd_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bqd_pkg::ADDR_W-1:0]    paddr,
   input  logic [bqd_pkg::PDATA_W-1:0]   pwdata,
   output logic [bqd_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int SAT_W  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int AW     = bqd_pkg::ACC_W;
   localparam int MW     = bqd_pkg::MUL_W;
   localparam int PW     = bqd_pkg::PROD_W;
   localparam int NW     = bqd_pkg::NUM_W;
   localparam int SW     = bqd_pkg::STEP_W;
   localparam int DW     = bqd_pkg::SAMPLE_W;
   localparam int CW     = bqd_pkg::CNT_W;
   localparam int QW     = bqd_pkg::DIV_BITS;

   localparam logic signed [AW-1:0] ACC_HI =
      {{(AW-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
   localparam logic signed [AW-1:0] ACC_LO =
      {{(AW-SAT_W+1){1'b1}}, {(SAT_W-1){1'b0}}};
   localparam logic signed [DW-1:0] IN_HI =
      {{(DW-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
   localparam logic signed [DW-1:0] IN_LO =
      {{(DW-SAT_W+1){1'b1}}, {(SAT_W-1){1'b0}}};
   localparam logic signed [AW-1:0] ROUND_K =
      {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic [CW-1:0] MAC_LAST = CW'(4);
   localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [bqd_pkg::COEF_W-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff;
   logic signed [bqd_pkg::COEF_W-1:0] coef_a1_ff, coef_a2_ff;
   logic                              csr_write;
   logic [2:0]                        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[bqd_pkg::ADDR_W-1:2];

   // Write coefficients on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= bqd_pkg::COEF_W'(1) << COEF_FRAC_BITS;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            bqd_pkg::REG_B0: coef_b0_ff <= pwdata;
            bqd_pkg::REG_B1: coef_b1_ff <= pwdata;
            bqd_pkg::REG_B2: coef_b2_ff <= pwdata;
            bqd_pkg::REG_A1: coef_a1_ff <= pwdata;
            bqd_pkg::REG_A2: coef_a2_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         bqd_pkg::REG_B0: prdata = coef_b0_ff;
         bqd_pkg::REG_B1: prdata = coef_b1_ff;
         bqd_pkg::REG_B2: prdata = coef_b2_ff;
         bqd_pkg::REG_A1: prdata = coef_a1_ff;
         bqd_pkg::REG_A2: prdata = coef_a2_ff;
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   bqd_pkg::state_type     state_ff, state_in;
   logic                   primed_ff, primed_in;
   logic                   have_last_ff, have_last_in;
   logic                   acc_vld_ff, acc_vld_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   logic signed [SAT_W-1:0] x_ff, x_in;
   logic signed [SAT_W-1:0] ih1_ff, ih1_in, ih2_ff, ih2_in;
   logic signed [SAT_W-1:0] oh1_ff, oh1_in, oh2_ff, oh2_in;
   logic signed [SAT_W-1:0] last_ff, last_in;
   logic [SW-1:0]           step_ff, step_in;
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic                    sub_ff, sub_in;
   logic signed [MW-1:0]    diff_ff, diff_in;
   logic [NW-1:0]           num_ff, num_in;
   logic [SW-1:0]           rem_ff, rem_in;
   logic [QW-1:0]           quo_ff, quo_in;
   logic                    ovf_ff, ovf_in;
   logic signed [DW-1:0]    rate_ff, rate_in;
   logic                    rv_ff, rv_in;
   logic signed [DW-1:0]    out_filt_ff, out_filt_in;
   logic signed [DW-1:0]    out_rate_ff, out_rate_in;
   logic                    out_rv_ff, out_rv_in;

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   logic                    seq_idle;
   logic                    req_fire;
   logic                    preset_fire;
   logic                    sample_fire;
   logic signed [SAT_W-1:0] x_sat;
   logic signed [MW-1:0]    op_a, op_b;
   logic signed [AW-1:0]    acc_round, acc_shift;
   logic signed [SAT_W-1:0] y_sat;
   logic signed [PW-1:0]    prod_abs;
   logic [SW:0]             trial;
   logic                    trial_ge;
   logic [SW-1:0]           num_top;
   logic                    rate_neg;
   logic signed [DW-1:0]    rate_sat;

   assign seq_idle     = (state_ff == bqd_pkg::ST_IDLE);
   assign req_if.ready = seq_idle;
   assign req_fire     = req_if.valid && req_if.ready;
   assign preset_fire  = req_fire && (req_if.kind == bqd_pkg::KIND_PRESET);
   assign sample_fire  = req_fire && (req_if.kind == bqd_pkg::KIND_SAMPLE);

   // Saturate the sample into the data range
   always_comb begin
      if (req_if.sample_value > IN_HI) begin
         x_sat = IN_HI[SAT_W-1:0];
      end else if (req_if.sample_value < IN_LO) begin
         x_sat = IN_LO[SAT_W-1:0];
      end else begin
         x_sat = req_if.sample_value[SAT_W-1:0];
      end
   end

   // Select multiplier operands: five biquad taps, then the rate scale
   always_comb begin
      op_a = diff_ff;
      op_b = bqd_pkg::US_PER_SECOND;
      if (state_ff == bqd_pkg::ST_MAC) begin
         unique case (cnt_ff[2:0])
            3'd0: begin
               op_a = MW'(x_ff);
               op_b = MW'(coef_b0_ff);
            end
            3'd1: begin
               op_a = MW'(ih1_ff);
               op_b = MW'(coef_b1_ff);
            end
            3'd2: begin
               op_a = MW'(ih2_ff);
               op_b = MW'(coef_b2_ff);
            end
            3'd3: begin
               op_a = MW'(oh1_ff);
               op_b = MW'(coef_a1_ff);
            end
            default: begin
               op_a = MW'(oh2_ff);
               op_b = MW'(coef_a2_ff);
            end
         endcase
      end
   end

   assign prod_in = op_a * op_b;

   // Round to nearest, ties up, then saturate
   assign acc_round = acc_ff + ROUND_K;
   assign acc_shift = acc_round >>> COEF_FRAC_BITS;

   always_comb begin
      if (acc_shift > ACC_HI) begin
         y_sat = ACC_HI[SAT_W-1:0];
      end else if (acc_shift < ACC_LO) begin
         y_sat = ACC_LO[SAT_W-1:0];
      end else begin
         y_sat = acc_shift[SAT_W-1:0];
      end
   end

   assign prod_abs = prod_ff[PW-1] ? -prod_ff : prod_ff;

   // One restoring divide step
   assign trial    = {rem_ff, num_ff[QW-1]};
   assign trial_ge = (trial >= {1'b0, step_ff});
   assign num_top  = num_ff[NW-1:QW];

   // Saturate the signed quotient to 32 bits
   assign rate_neg = diff_ff[MW-1];
   always_comb begin
      if (!rate_neg) begin
         if (ovf_ff || quo_ff[QW-1] || quo_ff[QW-2]) begin
            rate_sat = {1'b0, {(DW-1){1'b1}}};
         end else begin
            rate_sat = quo_ff[DW-1:0];
         end
      end else begin
         if (ovf_ff || quo_ff[QW-1] || (quo_ff[QW-2] && (quo_ff[QW-3:0] != '0))) begin
            rate_sat = {1'b1, {(DW-1){1'b0}}};
         end else begin
            rate_sat = -quo_ff[DW-1:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      primed_in    = primed_ff;
      have_last_in = have_last_ff;
      acc_vld_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      ih1_in       = ih1_ff;
      ih2_in       = ih2_ff;
      oh1_in       = oh1_ff;
      oh2_in       = oh2_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sub_in       = sub_ff;
      diff_in      = diff_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      rate_in      = rate_ff;
      rv_in        = rv_ff;
      out_filt_in  = out_filt_ff;
      out_rate_in  = out_rate_ff;
      out_rv_in    = out_rv_ff;

      // Accumulate the product issued in the previous cycle
      if (acc_vld_ff) begin
         acc_in = sub_ff ? acc_ff - AW'(prod_ff) : acc_ff + AW'(prod_ff);
      end

      unique case (state_ff)
         bqd_pkg::ST_IDLE: begin
            if (req_fire) begin
               step_in = req_if.step_us;
               x_in    = x_sat;
               if (req_if.kind == bqd_pkg::KIND_PRESET || !primed_ff) begin
                  // Preload history from the value
                  ih1_in    = x_sat;
                  ih2_in    = x_sat;
                  oh1_in    = x_sat;
                  oh2_in    = x_sat;
                  last_in   = x_sat;
                  primed_in = 1'b1;
                  if (req_if.kind == bqd_pkg::KIND_PRESET) begin
                     have_last_in = 1'b0;
                  end else begin
                     have_last_in = 1'b1;
                     rate_in      = '0;
                     rv_in        = 1'b0;
                     state_in     = bqd_pkg::ST_DONE;
                  end
               end else begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = bqd_pkg::ST_MAC;
               end
            end
         end
         bqd_pkg::ST_MAC: begin
            acc_vld_in = 1'b1;
            sub_in     = (cnt_ff[2:0] >= 3'd3);
            cnt_in     = cnt_ff + CW'(1);
            if (cnt_ff == MAC_LAST) begin
               state_in = bqd_pkg::ST_DRAIN;
            end
         end
         bqd_pkg::ST_DRAIN: begin
            state_in = bqd_pkg::ST_ROUND;
         end
         bqd_pkg::ST_ROUND: begin
            // Shift the history
            ih2_in   = ih1_ff;
            ih1_in   = x_ff;
            oh2_in   = oh1_ff;
            oh1_in   = y_sat;
            state_in = bqd_pkg::ST_DIFF;
         end
         bqd_pkg::ST_DIFF: begin
            diff_in      = MW'(oh1_ff) - MW'(last_ff);
            last_in      = oh1_ff;
            have_last_in = 1'b1;
            if (have_last_ff && (step_ff > SW'(1))) begin
               state_in = bqd_pkg::ST_RMUL;
            end else begin
               rate_in  = '0;
               rv_in    = 1'b0;
               state_in = bqd_pkg::ST_DONE;
            end
         end
         bqd_pkg::ST_RMUL: begin
            state_in = bqd_pkg::ST_ABS;
         end
         bqd_pkg::ST_ABS: begin
            num_in   = prod_abs[NW-1:0];
            state_in = bqd_pkg::ST_ADD;
         end
         bqd_pkg::ST_ADD: begin
            // Add half the step for round-to-nearest
            num_in   = num_ff + NW'(step_ff[SW-1:1]);
            state_in = bqd_pkg::ST_CHECK;
         end
         bqd_pkg::ST_CHECK: begin
            rem_in = num_top;
            cnt_in = '0;
            if (num_top >= step_ff) begin
               ovf_in   = 1'b1;
               state_in = bqd_pkg::ST_SAT;
            end else begin
               ovf_in   = 1'b0;
               state_in = bqd_pkg::ST_DIV;
            end
         end
         bqd_pkg::ST_DIV: begin
            rem_in = trial_ge ? SW'(trial - {1'b0, step_ff}) : trial[SW-1:0];
            quo_in = {quo_ff[QW-2:0], trial_ge};
            num_in = {num_ff[NW-1:QW], num_ff[QW-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = bqd_pkg::ST_SAT;
            end
         end
         bqd_pkg::ST_SAT: begin
            rate_in  = rate_sat;
            rv_in    = 1'b1;
            state_in = bqd_pkg::ST_DONE;
         end
         bqd_pkg::ST_DONE: begin
            // Hand off once the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               out_filt_in  = DW'(oh1_ff);
               out_rate_in  = rate_ff;
               out_rv_in    = rv_ff;
               state_in     = bqd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqd_pkg::ST_IDLE;
         primed_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         have_last_ff <= have_last_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      ih1_ff      <= ih1_in;
      ih2_ff      <= ih2_in;
      oh1_ff      <= oh1_in;
      oh2_ff      <= oh2_in;
      last_ff     <= last_in;
      step_ff     <= step_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      sub_ff      <= sub_in;
      diff_ff     <= diff_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      rate_ff     <= rate_in;
      rv_ff       <= rv_in;
      out_filt_ff <= out_filt_in;
      out_rate_ff <= out_rate_in;
      out_rv_ff   <= out_rv_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.filtered_value = out_filt_ff;
   assign rsp_if.rate_value     = out_rate_ff;
   assign rsp_if.rate_valid     = out_rv_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `BQD_ASSERT_NEXT(a_preset_idle, clock, reset, preset_fire, seq_idle && primed_ff && !have_last_ff)
   `BQD_ASSERT_NEXT(a_sample_busy, clock, reset, sample_fire, !seq_idle && primed_ff)
   `BQD_ASSERT_IMPL(a_div_rem_below, clock, reset, state_ff == bqd_pkg::ST_DIV, rem_ff < step_ff)
   `BQD_ASSERT_IMPL(a_zero_rate, clock, reset, rsp_valid_ff && !out_rv_ff, out_rate_ff == '0)

endmodule

[test/tb_biquad_lowpass_derivative_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the biquad low-pass derivative core
// Sends sample and preset transactions through several coefficient sets,
// predicts each filtered value and rate in the bench, and checks every
// response field by field, with random gaps, stalls and long hold-offs.
// ----------------------------------------------------------------------------
module tb_biquad_lowpass_derivative_core;

   localparam int FRAC_BITS     = bqd_pkg::COEF_FRAC_BITS_DEF;
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD     = 400;

   typedef struct {
      logic                                kind;
      logic signed [bqd_pkg::SAMPLE_W-1:0] sample_value;
      logic        [bqd_pkg::STEP_W-1:0]   step_us;
   } sample_txn_type;

   typedef struct {
      logic signed [bqd_pkg::SAMPLE_W-1:0] filtered;
      logic signed [bqd_pkg::SAMPLE_W-1:0] rate;
      logic                                rate_valid;
   } filter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [bqd_pkg::ADDR_W-1:0]  paddr = '0;
   logic [bqd_pkg::PDATA_W-1:0] pwdata = '0;
   logic [bqd_pkg::PDATA_W-1:0] prdata;
   logic pready;

   bqd_req_if req_ch ();
   bqd_rsp_if rsp_ch ();

   biquad_lowpass_derivative_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   // Bench copy of the filter state and coefficients
   logic signed [bqd_pkg::COEF_W-1:0]   coef_reg [5];
   logic signed [bqd_pkg::SAMPLE_W-1:0] x_hist1 = '0, x_hist2 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] y_hist1 = '0, y_hist2 = '0;
   logic signed [bqd_pkg::SAMPLE_W-1:0] last_filt = '0;
   bit primed = 1'b0;
   bit have_prev = 1'b0;

   sample_txn_type pending_txns [$];
   filter_out_type expected_outs [$];

   int mismatches = 0;
   int txn_count = 0;
   int preset_count = 0;
   int result_count = 0;
   int rate_count = 0;
   int coef_sets = 1;
   bit no_idle = 1'b0;

   function automatic logic signed [31:0] sat32(logic signed [69:0] v);
      if (v > 70'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -70'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
   endtask

   // Advance the bench filter by one accepted transaction
   task automatic advance_filter(logic kind, logic signed [31:0] x, logic [19:0] step);
      logic signed [69:0] acc;
      logic signed [31:0] y;
      longint diff;
      longint unsigned mag, stp, quo;
      filter_out_type res;
      if (kind == bqd_pkg::KIND_PRESET) begin
         x_hist1 = x; x_hist2 = x; y_hist1 = x; y_hist2 = x;
         primed = 1'b1;
         last_filt = x;
         have_prev = 1'b0;
         return;
      end
      if (!primed) begin
         // first sample after power-up fills the history and passes through
         x_hist1 = x; x_hist2 = x; y_hist1 = x; y_hist2 = x;
         primed = 1'b1;
         y = x;
      end else begin
         acc = longint'(coef_reg[bqd_pkg::REG_B0]) * longint'(x);
         acc += longint'(coef_reg[bqd_pkg::REG_B1]) * longint'(x_hist1);
         acc += longint'(coef_reg[bqd_pkg::REG_B2]) * longint'(x_hist2);
         acc -= longint'(coef_reg[bqd_pkg::REG_A1]) * longint'(y_hist1);
         acc -= longint'(coef_reg[bqd_pkg::REG_A2]) * longint'(y_hist2);
         // round half up while dropping the coefficient fraction
         acc = (acc + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         y = sat32(acc);
         x_hist2 = x_hist1; x_hist1 = x;
         y_hist2 = y_hist1; y_hist1 = y;
      end
      res.filtered = y;
      res.rate = '0;
      res.rate_valid = 1'b0;
      if (have_prev && step > 20'd1) begin
         diff = longint'(y) - longint'(last_filt);
         mag = (diff < 0 ? -diff : diff) * 1000000;
         stp = step;
         quo = (mag + (stp >> 1)) / stp;
         res.rate = sat32(diff < 0 ? -longint'(quo) : longint'(quo));
         res.rate_valid = 1'b1;
      end
      last_filt = y;
      have_prev = 1'b1;
      expected_outs.push_back(res);
   endtask

   // Request driver: present queued transactions with random gaps
   int unsigned gap_left = 0;
   always @(posedge clock) begin
      sample_txn_type txn;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left <= 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the current transaction
      end else if (gap_left != 0) begin
         req_ch.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_txns.size() != 0) begin
         txn = pending_txns.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.kind <= txn.kind;
         req_ch.sample_value <= txn.sample_value;
         req_ch.step_us <= txn.step_us;
         gap_left <= no_idle ? 0 : $urandom_range(0, 14);
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Request monitor: predict on every accepted transaction
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         txn_count++;
         if (req_ch.kind == bqd_pkg::KIND_PRESET) preset_count++;
         advance_filter(req_ch.kind, req_ch.sample_value, req_ch.step_us);
      end
   end

   // Long hold-off of the response side, twice per run
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && txn_count >= (holds_done == 0 ? 300 : 1100)) begin
         hold_left <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   // Response ready: random stall after each transaction
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      int unsigned draw;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         draw = no_idle ? 0 : $urandom_range(0, 14);
         stall_left <= draw;
         rsp_ch.ready <= (draw == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Response monitor: compare against the oldest prediction
   always @(posedge clock) begin
      filter_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outs.size() == 0) begin
            note_mismatch($sformatf("unexpected response filtered=%0d rate=%0d",
                                    rsp_ch.filtered_value, rsp_ch.rate_value));
         end else begin
            want = expected_outs.pop_front();
            result_count++;
            if (want.rate_valid) rate_count++;
            if (rsp_ch.filtered_value !== want.filtered)
               note_mismatch($sformatf("filtered_value %0d, want %0d",
                                       rsp_ch.filtered_value, want.filtered));
            if (rsp_ch.rate_value !== want.rate)
               note_mismatch($sformatf("rate_value %0d, want %0d",
                                       rsp_ch.rate_value, want.rate));
            if (rsp_ch.rate_valid !== want.rate_valid)
               note_mismatch($sformatf("rate_valid %0b, want %0b",
                                       rsp_ch.rate_valid, want.rate_valid));
         end
      end
   end

   task automatic queue_txn(logic kind, logic signed [31:0] value, logic [19:0] step);
      sample_txn_type txn;
      txn.kind = kind;
      txn.sample_value = value;
      txn.step_us = step;
      pending_txns.push_back(txn);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2, 3, 4: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [19:0] random_step();
      case ($urandom_range(0, 7))
         0:       return 20'($urandom_range(0, 1));
         1:       return 20'd2;
         2:       return 20'hFFFFF;
         3, 4:    return 20'($urandom_range(2, 5000));
         default: return 20'($urandom());
      endcase
   endfunction

   function automatic logic signed [31:0] random_coef(bit full_range);
      if (full_range) return $urandom();
      return 32'($urandom_range(0, 1 << (FRAC_BITS + 1))) - (32'd1 << FRAC_BITS);
   endfunction

   // Wait until the core has nothing in flight, then let it settle
   task automatic drain_core();
      do @(negedge clock);
      while (pending_txns.size() != 0 || req_ch.valid || expected_outs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one coefficient, then read it back; each access is setup plus access
   task automatic write_coef(bqd_pkg::reg_index_type idx, logic signed [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value || pready !== 1'b1)
         note_mismatch($sformatf("read back of register %0d gave %0h, want %0h",
                                 idx, prdata, value));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      coef_reg[idx] = value;
   endtask

   task automatic load_coefs(logic signed [31:0] b0, logic signed [31:0] b1,
                             logic signed [31:0] b2, logic signed [31:0] a1,
                             logic signed [31:0] a2);
      drain_core();
      write_coef(bqd_pkg::REG_B0, b0);
      write_coef(bqd_pkg::REG_B1, b1);
      write_coef(bqd_pkg::REG_B2, b2);
      write_coef(bqd_pkg::REG_A1, a1);
      write_coef(bqd_pkg::REG_A2, a2);
      coef_sets++;
   endtask

   // Random transactions, mostly samples with an occasional preset
   task automatic queue_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 11) == 0)
            queue_txn(bqd_pkg::KIND_PRESET, random_value(), 20'($urandom()));
         else
            queue_txn(bqd_pkg::KIND_SAMPLE, random_value(), random_step());
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = bqd_pkg::KIND_SAMPLE;
      req_ch.sample_value = '0;
      req_ch.step_us = '0;
      rsp_ch.ready = 1'b0;
      coef_reg[bqd_pkg::REG_B0] = 32'sd1 <<< FRAC_BITS;
      coef_reg[bqd_pkg::REG_B1] = '0;
      coef_reg[bqd_pkg::REG_B2] = '0;
      coef_reg[bqd_pkg::REG_A1] = '0;
      coef_reg[bqd_pkg::REG_A2] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: priming, extremes of value and step, presets
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd12345 <<< 16, 20'd1000);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sh7FFFFFFF, 20'd1000);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sh80000000, 20'd2);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd0, 20'd0);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd1, 20'd1);
      queue_txn(bqd_pkg::KIND_SAMPLE, -32'sd1, 20'hFFFFF);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd3, 20'd3);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sh55555555, 20'h55555);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'shAAAAAAAA, 20'hAAAAA);
      queue_txn(bqd_pkg::KIND_PRESET, 32'sh7FFFFFFF, 20'hFFFFF);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd0, 20'd5);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd7, 20'd2);
      queue_txn(bqd_pkg::KIND_PRESET, 32'sh80000000, 20'd0);
      queue_txn(bqd_pkg::KIND_PRESET, 32'sd0, 20'd7);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sd100, 20'd200);
      queue_txn(bqd_pkg::KIND_SAMPLE, -32'sd100, 20'd3);
      queue_txn(bqd_pkg::KIND_SAMPLE, 32'sh80000000, 20'hFFFFF);
      queue_random(200);

      // Butterworth-like low-pass, no idling on either side
      load_coefs(32'sd18119393, 32'sd36238786, 32'sd18119393,
                 -32'sd306821826, 32'sd110810156);
      no_idle = 1'b1;
      queue_random(200);
      drain_core();
      no_idle = 1'b0;

      // Coefficient extremes
      load_coefs(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      queue_random(150);
      load_coefs(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      queue_random(150);

      // Random coefficients, full range and near unity
      load_coefs(random_coef(1), random_coef(1), random_coef(1), random_coef(1),
                 random_coef(1));
      queue_random(200);
      load_coefs(random_coef(0), random_coef(0), random_coef(0), random_coef(0),
                 random_coef(0));
      queue_random(200);

      // Mixed extremes
      load_coefs(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sh80000000, 32'sh7FFFFFFF);
      queue_random(150);

      // Back to the pass-through setting, first half without idling
      load_coefs(32'sd1 <<< FRAC_BITS, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      no_idle = 1'b1;
      queue_random(120);
      drain_core();
      no_idle = 1'b0;
      queue_random(130);
      drain_core();

      $display("Covered %0d transactions (%0d presets) over %0d coefficient sets",
               txn_count, preset_count, coef_sets);
      $display("Checked %0d responses, %0d with a computed rate, %0d mismatches",
               result_count, rate_count, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding", expected_outs.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
